### rtl/core/pwm_calibration_sweep_sequencer_core_assert.svh
// assertion macros for the sweep sequencer core
`ifndef PWM_CALIBRATION_SWEEP_SEQUENCER_CORE_ASSERT_SVH
`define PWM_CALIBRATION_SWEEP_SEQUENCER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PCSS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define PCSS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/pcss_pkg.sv
// shared types and constants of the sweep sequencer core
package pcss_pkg;

   localparam int PWM_W      = 10;
   localparam int PWMCMD_W   = 11;
   localparam int MS_W       = 16;
   localparam int TIME_W     = 32;
   localparam int STEP_W     = 10;
   localparam int PROD_W     = PWM_W + STEP_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 32;
   localparam int DIV_CNT_W  = 4;

   localparam int unsigned PWM_FULL_SCALE = 1000;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_START = 2'd1,
      CMD_ABORT = 2'd2
   } cmd_code_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_FWD  = 2'd1,
      PH_REV  = 2'd2
   } phase_type;

   localparam logic [CSR_IDX_W-1:0] REG_SWEEP_START  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SWEEP_END    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SWEEP_STEP   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DWELL        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SETTLE       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_PER   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_RUN_PWM      = 3'd6;

   // controller to datapath
   typedef struct packed {
      logic latch_in;
      logic div_start;
      logic start_sweep;
      logic set_total;
      logic refuse;
      logic abort;
      logic advance;
      logic to_reverse;
      logic finish;
      logic sample;
      logic mul;
      logic apply;
      logic emit;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      cmd_code_type cmd;
      logic         active;
      logic         fwd;
      logic         dwell_hit;
      logic         settle_hit;
      logic         period_hit;
      logic         last_step;
      logic         div_done;
      logic         out_free;
   } dp_status_type;

endpackage

### rtl/core/pwm_calibration_sweep_sequencer_core.sv
// top level of the pwm calibration sweep sequencer core
//
// channel   direction  ports                         contents
// req       in         req_tvalid/tready/tdata/tuser tdata: now_ms; tuser: cmd
// rsp       out        rsp_tvalid/tready/tdata       one result per request transfer
// csr       in         csr_valid/ready/index/wdata   settings writes, always ready
//
// a tick passes through decide and emit; a step change also through multiply and apply
// a start also waits for the step-count divider, which gives one quotient bit per cycle
// one request is in flight at a time; the next is taken while its result waits
// a stalled rsp side holds the controller in its emit state
// reset is synchronous and loads the default settings and an idle sweep
`include "pwm_calibration_sweep_sequencer_core_assert.svh"

module pwm_calibration_sweep_sequencer_core import pcss_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [TIME_W-1:0]     req_tdata,   // [31:0] now_ms
   input  logic [REQ_USER_W-1:0] req_tuser,   // [1:0] cmd
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [10:0] pwm_cmd, [11] pwm_write, [12] brake_pulse, [13] sample_now,
   // [15:14] phase, [25:16] step_index, [26] sweep_done, [27] start_refused, [31:28] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // state machine: decide, then divide, multiply and apply as the request needs, then emit
   pcss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (dp_status),
      .cmd        (dp_cmd)
   );

   // settings, sweep state, timers, step arithmetic and the result register
   pcss_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (dp_cmd),
      .status     (dp_status),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // completion always writes the restored pwm and leaves the sweep idle
   `PCSS_ASSERT_NOW(a_done_idle, clock, reset, rsp_tvalid && rsp_tdata[26],
      rsp_tdata[11] && (rsp_tdata[15:14] == PH_IDLE), "sweep done without write or idle phase")

   // an abort brakes and never writes a new pwm in the same result
   `PCSS_ASSERT_NOW(a_brake_no_write, clock, reset, rsp_tvalid && rsp_tdata[12],
      !rsp_tdata[11] && (rsp_tdata[15:14] == PH_IDLE), "brake result with pwm write")

   // one request at a time: the controller leaves idle after each request transfer
   `PCSS_ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready,
      !req_tready, "request taken while another is in flight")

endmodule

### rtl/core/pcss_div.sv
// restoring divider for the step count, one quotient bit per cycle
module pcss_div import pcss_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [PWM_W-1:0] dividend,
   input  logic [PWM_W-1:0] divisor,
   output logic             done,
   output logic [PWM_W-1:0] quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [PWM_W-1:0]     rem_ff, rem_in;
   logic [PWM_W-1:0]     quo_ff, quo_in;
   logic [PWM_W-1:0]     dvs_ff, dvs_in;
   logic [PWM_W:0]       shifted;
   logic [PWM_W:0]       diff;
   logic                 ge;

   assign shifted = {rem_ff, quo_ff[PWM_W-1]};
   assign ge      = shifted >= {1'b0, dvs_ff};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[PWM_W-1:0] : shifted[PWM_W-1:0];
         quo_in = {quo_ff[PWM_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(PWM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### rtl/core/pcss_dp.sv
// datapath: settings, sweep state, step arithmetic and result register
module pcss_dp import pcss_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  logic [TIME_W-1:0]     req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // settings
   logic [PWM_W-1:0] start_ff, start_in;
   logic [PWM_W-1:0] end_ff, end_in;
   logic [PWM_W-1:0] step_ff, step_in;
   logic [MS_W-1:0]  dwell_ff, dwell_in;
   logic [MS_W-1:0]  settle_ff, settle_in;
   logic [MS_W-1:0]  period_ff, period_in;
   logic [PWM_W-1:0] run_pwm_ff, run_pwm_in;

   // sweep state
   phase_type         phase_ff, phase_in;
   logic [STEP_W-1:0] step_count_ff, step_count_in;
   logic [STEP_W-1:0] total_ff, total_in;
   logic [TIME_W-1:0] step_start_ff, step_start_in;
   logic [TIME_W-1:0] last_sample_ff, last_sample_in;
   logic [PWM_W-1:0]  saved_ff, saved_in;

   // current item and its result
   cmd_code_type             cmd_ff, cmd_in;
   logic [TIME_W-1:0]        now_ff, now_in;
   logic [PROD_W-1:0]        product_ff, product_in;
   logic signed [PWMCMD_W-1:0] res_pwm_ff, res_pwm_in;
   logic                     res_wr_ff, res_wr_in;
   logic                     res_brake_ff, res_brake_in;
   logic                     res_sample_ff, res_sample_in;
   logic                     res_done_ff, res_done_in;
   logic                     res_refused_ff, res_refused_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [PWM_W-1:0]    step_size;
   logic [PWM_W-1:0]    diff_pwm;
   logic                div_done;
   logic [PWM_W-1:0]    div_quo;
   logic [TIME_W-1:0]   elapsed;
   logic [TIME_W-1:0]   since_sample;
   logic [STEP_W-1:0]   next_count;
   logic [PROD_W:0]     mag_sum;
   logic [PROD_W:0]     mag_end;
   logic [PROD_W:0]     mag_clamp;
   logic [PWMCMD_W-1:0] mag_ext;

   assign step_size    = (step_ff == '0) ? PWM_W'(1) : step_ff;
   assign diff_pwm     = (end_ff >= start_ff) ? (end_ff - start_ff) : '0;
   assign elapsed      = now_ff - step_start_ff;
   assign since_sample = now_ff - last_sample_ff;
   assign next_count   = step_count_ff + 1'b1;

   // clamp to the end magnitude and to full scale
   assign mag_sum   = {1'b0, product_ff} + (PROD_W + 1)'(start_ff);
   assign mag_end   = (mag_sum > (PROD_W + 1)'(end_ff)) ? (PROD_W + 1)'(end_ff) : mag_sum;
   assign mag_clamp = (mag_end > (PROD_W + 1)'(PWM_FULL_SCALE)) ?
                      (PROD_W + 1)'(PWM_FULL_SCALE) : mag_end;
   assign mag_ext   = {1'b0, mag_clamp[PWM_W-1:0]};

   pcss_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (diff_pwm),
      .divisor  (step_size),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      start_in       = start_ff;
      end_in         = end_ff;
      step_in        = step_ff;
      dwell_in       = dwell_ff;
      settle_in      = settle_ff;
      period_in      = period_ff;
      run_pwm_in     = run_pwm_ff;
      phase_in       = phase_ff;
      step_count_in  = step_count_ff;
      total_in       = total_ff;
      step_start_in  = step_start_ff;
      last_sample_in = last_sample_ff;
      saved_in       = saved_ff;
      cmd_in         = cmd_ff;
      now_in         = now_ff;
      product_in     = product_ff;
      res_pwm_in     = res_pwm_ff;
      res_wr_in      = res_wr_ff;
      res_brake_in   = res_brake_ff;
      res_sample_in  = res_sample_ff;
      res_done_in    = res_done_ff;
      res_refused_in = res_refused_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;

      if (csr_valid) begin
         unique case (csr_index)
            REG_SWEEP_START: start_in   = csr_wdata[PWM_W-1:0];
            REG_SWEEP_END:   end_in     = csr_wdata[PWM_W-1:0];
            REG_SWEEP_STEP:  step_in    = csr_wdata[PWM_W-1:0];
            REG_DWELL:       dwell_in   = csr_wdata;
            REG_SETTLE:      settle_in  = csr_wdata;
            REG_SAMPLE_PER:  period_in  = csr_wdata;
            REG_RUN_PWM:     run_pwm_in = csr_wdata[PWM_W-1:0];
            default: ;
         endcase
      end

      if (cmd.latch_in) begin
         cmd_in         = cmd_code_type'(req_tuser);
         now_in         = req_tdata;
         res_pwm_in     = '0;
         res_wr_in      = 1'b0;
         res_brake_in   = 1'b0;
         res_sample_in  = 1'b0;
         res_done_in    = 1'b0;
         res_refused_in = 1'b0;
      end
      if (cmd.start_sweep) begin
         saved_in      = run_pwm_ff;
         step_count_in = '0;
         phase_in      = PH_FWD;
      end
      if (cmd.set_total) begin
         total_in = (div_quo == '1) ? div_quo : div_quo + 1'b1;
      end
      if (cmd.refuse) begin
         res_refused_in = 1'b1;
      end
      if (cmd.abort) begin
         phase_in     = PH_IDLE;
         run_pwm_in   = saved_ff;
         res_brake_in = 1'b1;
      end
      if (cmd.advance) begin
         step_count_in = next_count;
      end
      if (cmd.to_reverse) begin
         phase_in      = PH_REV;
         step_count_in = '0;
      end
      if (cmd.finish) begin
         phase_in    = PH_IDLE;
         run_pwm_in  = saved_ff;
         res_pwm_in  = {1'b0, saved_ff};
         res_wr_in   = 1'b1;
         res_done_in = 1'b1;
      end
      if (cmd.sample) begin
         last_sample_in = now_ff;
         res_sample_in  = 1'b1;
      end
      if (cmd.mul) begin
         product_in = step_count_ff * step_size;
      end
      if (cmd.apply) begin
         res_pwm_in     = (phase_ff == PH_FWD) ? mag_ext : -mag_ext;
         res_wr_in      = 1'b1;
         step_start_in  = now_ff;
         last_sample_in = now_ff;
      end

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {4'b0000, res_refused_ff, res_done_ff, step_count_ff, phase_ff,
                         res_sample_ff, res_brake_ff, res_wr_ff, res_pwm_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff       <= PWM_W'(0);
         end_ff         <= PWM_W'(100);
         step_ff        <= PWM_W'(5);
         dwell_ff       <= MS_W'(2000);
         settle_ff      <= MS_W'(500);
         period_ff      <= MS_W'(100);
         run_pwm_ff     <= PWM_W'(278);
         phase_ff       <= PH_IDLE;
         step_count_ff  <= '0;
         total_ff       <= '0;
         step_start_ff  <= '0;
         last_sample_ff <= '0;
         saved_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         start_ff       <= start_in;
         end_ff         <= end_in;
         step_ff        <= step_in;
         dwell_ff       <= dwell_in;
         settle_ff      <= settle_in;
         period_ff      <= period_in;
         run_pwm_ff     <= run_pwm_in;
         phase_ff       <= phase_in;
         step_count_ff  <= step_count_in;
         total_ff       <= total_in;
         step_start_ff  <= step_start_in;
         last_sample_ff <= last_sample_in;
         saved_ff       <= saved_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      cmd_ff         <= cmd_in;
      now_ff         <= now_in;
      product_ff     <= product_in;
      res_pwm_ff     <= res_pwm_in;
      res_wr_ff      <= res_wr_in;
      res_brake_ff   <= res_brake_in;
      res_sample_ff  <= res_sample_in;
      res_done_ff    <= res_done_in;
      res_refused_ff <= res_refused_in;
      rsp_data_ff    <= rsp_data_in;
   end

   always_comb begin
      status.cmd        = cmd_ff;
      status.active     = (phase_ff != PH_IDLE);
      status.fwd        = (phase_ff == PH_FWD);
      status.dwell_hit  = elapsed >= TIME_W'(dwell_ff);
      status.settle_hit = elapsed >= TIME_W'(settle_ff);
      status.period_hit = since_sample >= TIME_W'(period_ff);
      status.last_step  = next_count >= total_ff;
      status.div_done   = div_done;
      status.out_free   = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

endmodule

### rtl/core/pcss_ctrl.sv
// controller: sequences one item at a time through the datapath
module pcss_ctrl import pcss_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_DIV,
      ST_MUL,
      ST_APPLY,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.latch_in = 1'b1;
               state_in     = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = ST_EMIT;
            unique case (status.cmd)
               CMD_START: begin
                  if (status.active) begin
                     cmd.refuse = 1'b1;
                  end else begin
                     cmd.start_sweep = 1'b1;
                     cmd.div_start   = 1'b1;
                     state_in        = ST_DIV;
                  end
               end
               CMD_ABORT: begin
                  cmd.abort = status.active;
               end
               CMD_TICK: begin
                  if (status.active) begin
                     priority if (status.dwell_hit) begin
                        if (!status.last_step) begin
                           cmd.advance = 1'b1;
                           state_in    = ST_MUL;
                        end else if (status.fwd) begin
                           cmd.to_reverse = 1'b1;
                           state_in       = ST_MUL;
                        end else begin
                           // the step index still moves past the last step
                           cmd.advance = 1'b1;
                           cmd.finish  = 1'b1;
                        end
                     end else if (status.settle_hit && status.period_hit) begin
                        cmd.sample = 1'b1;
                     end else begin
                     end
                  end
               end
               default: ;
            endcase
         end
         ST_DIV: begin
            if (status.div_done) begin
               cmd.set_total = 1'b1;
               state_in      = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

endmodule

### dv/tb_pwm_calibration_sweep_sequencer_core.sv
// self-checking testbench for the pwm calibration sweep sequencer core
module tb_pwm_calibration_sweep_sequencer_core;
   timeunit 1ns;
   timeprecision 1ps;

   import pcss_pkg::*;

   // command code outside the defined set, the block must treat it as a no-op
   localparam logic [1:0] CMD_RESERVED = 2'd3;

   // cycles allowed for the block to go quiet after the last result transfer
   localparam int DRAIN_CYCLES = 24;
   // hard stop, far above the slowest legal run
   localparam int CYCLE_LIMIT = 1_000_000;

   // result word as the block packs it onto rsp_tdata, msb first
   typedef struct packed {
      logic [3:0]  spare;
      logic        refused;
      logic        done;
      logic [9:0]  step_idx;
      phase_type   phase;
      logic        sample;
      logic        brake;
      logic        wr;
      logic [10:0] pwm;
   } sweep_report_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [TIME_W-1:0]     req_tdata  = '0;   // [31:0] now_ms
   logic [REQ_USER_W-1:0] req_tuser  = '0;   // [1:0] cmd
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [10:0] pwm_cmd, [11] pwm_write, [12] brake_pulse, [13] sample_now,
   // [15:14] phase, [25:16] step_index, [26] sweep_done, [27] start_refused, [31:28] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   pwm_calibration_sweep_sequencer_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // ------------------------------------------------------------------
   // sweep predictor: settings and state, loaded with the reset values
   // ------------------------------------------------------------------
   logic [9:0]         cfg_lo_pwm    = 10'd0;
   logic [9:0]         cfg_hi_pwm    = 10'd100;
   logic [9:0]         cfg_inc_pwm   = 10'd5;
   logic [15:0]        cfg_hold_ms   = 16'd2000;
   logic [15:0]        cfg_quiet_ms  = 16'd500;
   logic [15:0]        cfg_gap_ms    = 16'd100;
   logic [9:0]         cfg_run_pwm   = 10'd278;

   phase_type          sw_phase      = PH_IDLE;
   logic [9:0]         sw_step       = '0;
   logic [9:0]         sw_total      = '0;
   logic [31:0]        t_step_ms     = '0;
   logic [31:0]        t_sample_ms   = '0;
   logic signed [10:0] drive_pwm     = '0;
   logic [9:0]         parked_pwm    = '0;

   // predicted results in request order, one per accepted request
   sweep_report_type step_reports[$];

   int mismatch_count = 0;
   int cycle_count    = 0;
   int idle_pct       = 0;   // sender idles before a request, percent
   int stall_pct      = 0;   // receiver drops tready, percent per cycle
   int hold_cycles    = 0;   // long receiver hold-off, counts down in the ready process

   // a zero increment behaves as one
   function automatic int step_inc();
      return (cfg_inc_pwm == 10'd0) ? 1 : int'(cfg_inc_pwm);
   endfunction

   // new step magnitude, clamped to the end value and full scale, sign by direction
   function automatic void load_step(logic [31:0] now);
      int mag;
      mag = int'(cfg_lo_pwm) + int'(sw_step) * step_inc();
      if (mag > int'(cfg_hi_pwm)) mag = int'(cfg_hi_pwm);
      if (mag > int'(PWM_FULL_SCALE)) mag = int'(PWM_FULL_SCALE);
      drive_pwm   = (sw_phase == PH_FWD) ? 11'(mag) : 11'(-mag);
      t_step_ms   = now;
      t_sample_ms = now;
   endfunction

   // advance the sweep by one request and return what the block should answer
   function automatic sweep_report_type advance_sweep(logic [1:0] cmd, logic [31:0] now);
      sweep_report_type r;
      logic             active;
      logic [31:0]      elapsed;
      int               span;
      int               cnt;
      r       = '0;
      active  = (sw_phase == PH_FWD) || (sw_phase == PH_REV);
      elapsed = now - t_step_ms;
      case (cmd)
         CMD_START: begin
            if (active) begin
               r.refused = 1'b1;
            end else begin
               parked_pwm = cfg_run_pwm;
               span = (cfg_hi_pwm >= cfg_lo_pwm) ? int'(cfg_hi_pwm) - int'(cfg_lo_pwm) : 0;
               cnt  = span / step_inc() + 1;
               sw_total = (cnt > 1023) ? 10'd1023 : 10'(cnt);
               sw_step  = '0;
               sw_phase = PH_FWD;
               load_step(now);
               r.pwm = drive_pwm;
               r.wr  = 1'b1;
            end
         end
         CMD_ABORT: begin
            if (active) begin
               sw_phase    = PH_IDLE;
               cfg_run_pwm = parked_pwm;
               r.brake     = 1'b1;
            end
         end
         CMD_TICK: begin
            if (active && elapsed >= cfg_hold_ms) begin
               sw_step = sw_step + 10'd1;
               if (sw_step < sw_total) begin
                  load_step(now);
                  r.pwm = drive_pwm;
                  r.wr  = 1'b1;
               end else if (sw_phase == PH_FWD) begin
                  sw_phase = PH_REV;
                  sw_step  = '0;
                  load_step(now);
                  r.pwm = drive_pwm;
                  r.wr  = 1'b1;
               end else begin
                  sw_phase    = PH_IDLE;
                  cfg_run_pwm = parked_pwm;
                  r.pwm       = {1'b0, parked_pwm};
                  r.wr        = 1'b1;
                  r.done      = 1'b1;
               end
            end else if (active && elapsed >= cfg_quiet_ms &&
                         now - t_sample_ms >= cfg_gap_ms) begin
               t_sample_ms = now;
               r.sample    = 1'b1;
            end
         end
         default: ;
      endcase
      r.phase    = sw_phase;
      r.step_idx = sw_step;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // clock, cycle limit, receiver and result checker
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // a hung handshake or a lost result ends up here
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_pwm_calibration_sweep_sequencer_core: done, errors");
         $finish;
      end
   end

   // rsp_tready: long hold-off first, otherwise random stalls at the phase rate
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic void check_field(string name, logic signed [31:0] want,
                                       logic signed [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // every result transfer is matched against the oldest prediction
   always @(posedge clock) begin
      sweep_report_type got;
      sweep_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = sweep_report_type'(rsp_tdata);
         if (step_reports.size() == 0) begin
            $error("rsp transfer with nothing outstanding: tdata %h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = step_reports.pop_front();
            check_field("pwm_cmd", $signed(want.pwm), $signed(got.pwm));
            check_field("pwm_write", want.wr, got.wr);
            check_field("brake_pulse", want.brake, got.brake);
            check_field("sample_now", want.sample, got.sample);
            check_field("phase", want.phase, got.phase);
            check_field("step_index", want.step_idx, got.step_idx);
            check_field("sweep_done", want.done, got.done);
            check_field("start_refused", want.refused, got.refused);
            check_field("tdata[31:28]", want.spare, got.spare);
         end
      end
   end

   // ------------------------------------------------------------------
   // request and settings drivers
   // ------------------------------------------------------------------

   // one request transfer; tvalid stays high afterwards so back-to-back
   // requests need no gap, the caller lowers it through drain
   task automatic send_item(input logic [1:0] cmd, input logic [31:0] now);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= now;
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
      step_reports.push_back(advance_sweep(cmd, now));
   endtask

   // stop requesting, wait out every outstanding result, then let the core settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (step_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // settings write; csr_valid stays high for back-to-back writes
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[15:0];
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_SWEEP_START: cfg_lo_pwm   = val[9:0];
         REG_SWEEP_END:   cfg_hi_pwm   = val[9:0];
         REG_SWEEP_STEP:  cfg_inc_pwm  = val[9:0];
         REG_DWELL:       cfg_hold_ms  = val[15:0];
         REG_SETTLE:      cfg_quiet_ms = val[15:0];
         REG_SAMPLE_PER:  cfg_gap_ms   = val[15:0];
         REG_RUN_PWM:     cfg_run_pwm  = val[9:0];
         default: ;
      endcase
   endtask

   // full settings load, only ever with the core idle and nothing outstanding
   task automatic configure(input int lo, input int hi, input int inc, input int hold,
                            input int quiet, input int gap, input int run);
      drain();
      write_reg(REG_SWEEP_START, lo);
      write_reg(REG_SWEEP_END, hi);
      write_reg(REG_SWEEP_STEP, inc);
      write_reg(REG_DWELL, hold);
      write_reg(REG_SETTLE, quiet);
      write_reg(REG_SAMPLE_PER, gap);
      write_reg(REG_RUN_PWM, run);
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // reset settings, idle commands, settle and sample timing across the 2^32 wrap
   task automatic test_idle_and_defaults();
      logic [31:0] base;
      base = 32'hFFFF_FF00;
      idle_pct  = 0;
      stall_pct = 0;
      send_item(CMD_TICK, 32'd0);            // tick while idle
      send_item(CMD_ABORT, 32'd0);           // abort while idle
      send_item(CMD_RESERVED, 32'hFFFF_FFFF);
      send_item(CMD_START, base);
      send_item(CMD_TICK, base + 32'd100);   // still settling
      send_item(CMD_TICK, base + 32'd500);   // first strobe, timestamps wrapped
      send_item(CMD_TICK, base + 32'd550);   // inside the sample period
      send_item(CMD_TICK, base + 32'd600);
      send_item(CMD_START, base + 32'd700);  // refused, sweep running
      send_item(CMD_RESERVED, base + 32'd800);
      send_item(CMD_TICK, base + 32'd2000);  // dwell over, next step
      send_item(CMD_ABORT, base + 32'd2001);
   endtask

   // largest timing values, largest step, full-scale pwm in both directions
   task automatic test_range_extremes();
      configure(0, 1000, 1000, 65535, 65535, 65535, 1000);
      send_item(CMD_START, 32'd0);
      send_item(CMD_TICK, 32'd65534);
      send_item(CMD_TICK, 32'd65535);
      send_item(CMD_TICK, 32'd131070);       // forward done, reverse from zero
      send_item(CMD_TICK, 32'd196605);
      send_item(CMD_TICK, 32'd262140);       // sweep complete, running pwm restored
   endtask

   // end below start, zero step size, zero dwell and zero sample period
   task automatic test_special_cases();
      configure(7, 3, 0, 0, 0, 0, 123);
      send_item(CMD_START, 32'h1234_5678);
      send_item(CMD_TICK, 32'h1234_5678);
      send_item(CMD_TICK, 32'h1234_5678);
      configure(0, 2, 0, 0, 0, 0, 50);
      send_item(CMD_START, 32'h0000_0010);
      send_item(CMD_TICK, 32'h0000_0010);
      send_item(CMD_TICK, 32'h0000_0011);
      send_item(CMD_ABORT, 32'h0000_0012);
      configure(0, 100, 10, 9, 0, 0, 9);
      send_item(CMD_START, 32'hAAAA_5555);
      send_item(CMD_TICK, 32'hAAAA_5555);    // strobe on every tick
      send_item(CMD_TICK, 32'hAAAA_5555);
      send_item(CMD_ABORT, 32'hAAAA_5556);
   endtask

   // 1024 computed steps saturate at 1023; forward turns around after index 1022
   task automatic test_step_count_saturation();
      logic [31:0] ms;
      ms = 32'hFFFF_FE00;
      configure(0, 1023, 1, 0, 0, 1, 500);
      send_item(CMD_START, ms);
      repeat (1025) begin
         ms = ms + 32'd1;
         send_item(CMD_TICK, ms);
      end
      send_item(CMD_ABORT, ms);
   endtask

   // receiver holds off for a long stretch while requests keep coming
   task automatic test_output_backpressure();
      logic [31:0] ms;
      ms = $urandom();
      configure(0, 40, 10, 3, 1, 1, 640);
      idle_pct  = 0;
      stall_pct = 0;
      send_item(CMD_START, ms);
      hold_cycles = 400;
      repeat (40) begin
         ms = ms + 32'($urandom_range(0, 2));
         send_item(CMD_TICK, ms);
      end
      if (sw_phase != PH_IDLE) send_item(CMD_ABORT, ms);
   endtask

   // random settings, then mostly well-formed sweeps with random timing and
   // some noise: refused starts, reserved codes, aborts and timestamp jumps
   task automatic test_random_sweeps(input int n_items, input int idle, input int stall);
      int          lo, hi, span, inc, hold, quiet, gap, run;
      int          pick, delta_max, budget, sweep_items;
      logic [1:0]  noise_cmd;
      logic [31:0] ms;
      sweep_items = 0;
      ms = $urandom();
      while (sweep_items < n_items) begin
         lo   = $urandom_range(0, 1000);
         pick = $urandom_range(99);
         hi   = (pick < 10) ? $urandom_range(0, lo) : $urandom_range(lo, 1000);
         span = (hi > lo) ? hi - lo : 0;
         if (pick >= 10 && pick < 15) begin
            inc = 0;
            hi  = (lo + 3 > 1000) ? 1000 : lo + 3;
         end else begin
            inc = span / $urandom_range(1, 6);
            if (inc == 0) inc = $urandom_range(1, 1000);
         end
         pick = $urandom_range(99);
         if (pick < 75)      hold = $urandom_range(1, 40);
         else if (pick < 85) hold = 0;
         else if (pick < 92) hold = $urandom_range(1000, 65535);
         else                hold = 65535;
         quiet = $urandom_range(0, hold + 2);
         if (quiet > 65535) quiet = 65535;
         pick = $urandom_range(99);
         if (pick < 75)      gap = $urandom_range(1, hold / 4 + 2);
         else if (pick < 85) gap = 0;
         else                gap = $urandom_range(1, 65535);
         run = $urandom_range(0, 1000);
         configure(lo, hi, inc, hold, quiet, gap, run);
         idle_pct  = idle;
         stall_pct = stall;
         delta_max = hold / 3 + 1;

         // idle-state noise before the sweep
         if ($urandom_range(3) == 0) begin
            noise_cmd = 2'($urandom_range(0, 3));
            send_item(noise_cmd, ms);
         end
         send_item(CMD_START, ms);
         sweep_items++;
         budget = 200;
         while (sw_phase != PH_IDLE && budget > 0) begin
            pick = $urandom_range(99);
            if (pick < 84) begin
               ms = ms + 32'($urandom_range(0, delta_max));
               send_item(CMD_TICK, ms);
            end else if (pick < 88) begin
               send_item(CMD_START, ms);
            end else if (pick < 91) begin
               send_item(CMD_RESERVED, ms);
            end else if (pick < 94) begin
               send_item(CMD_ABORT, ms);
            end else begin
               send_item(CMD_TICK, $urandom());
            end
            sweep_items++;
            budget--;
         end
         // never change settings under a running sweep
         if (sw_phase != PH_IDLE) send_item(CMD_ABORT, ms);
      end
   endtask

   // ------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_and_defaults();
      test_range_extremes();
      test_special_cases();
      test_step_count_saturation();
      test_output_backpressure();
      test_random_sweeps(120, 0, 0);     // no idling
      test_random_sweeps(120, 50, 0);    // sender idle half the time
      test_random_sweeps(120, 0, 50);    // receiver stalling half the time
      test_random_sweeps(120, 15, 15);   // both sides idling
      drain();

      if (mismatch_count == 0) begin
         $display("tb_pwm_calibration_sweep_sequencer_core: done, clean");
      end else begin
         $display("tb_pwm_calibration_sweep_sequencer_core: done, errors");
      end
      $finish;
   end

endmodule
